>>> rtl/atrcs_pkg.sv
`timescale 1ns / 1ps

package atrcs_pkg;

   localparam int NumPatterns = 6;
   localparam int PatMax      = 8;

   localparam int PAT_OK    = 0;
   localparam int PAT_PROMPT = 1;
   localparam int PAT_ERROR = 2;
   localparam int PAT_FAIL  = 3;
   localparam int PAT_LED_ON  = 4;
   localparam int PAT_LED_OFF = 5;

   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_JOIN     = 3'd1;
   localparam logic [2:0] CMD_ANNOUNCE = 3'd3;
   localparam logic [2:0] CMD_SEND     = 3'd4;

   localparam logic [2:0] STEP_ANNOUNCE = 3'd3;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] cmd_type;
   typedef logic [2:0] step_type;
   typedef logic [2:0] prog_type;

   typedef struct packed {
      logic     hit;
      prog_type prog;
   } match_type;

   localparam byte_type PAT_TEXT [NumPatterns][PatMax] = '{
      '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3E, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A, 8'h00},
      '{8'h46, 8'h41, 8'h49, 8'h4C, 8'h0D, 8'h0A, 8'h00, 8'h00},
      '{8'h2B, 8'h50, 8'h49, 8'h44, 8'h2C, 8'h31, 8'h3A, 8'h31},
      '{8'h2B, 8'h50, 8'h49, 8'h44, 8'h2C, 8'h31, 8'h3A, 8'h30}
   };

   localparam int PAT_LEN [NumPatterns] = '{2, 2, 7, 6, 8, 8};

   // progress after a full match (longest proper border)
   localparam prog_type PAT_BORDER [NumPatterns] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};

   // overlapping prefix match: longest prefix that ends the text so far
   function automatic match_type match_next(input int idx, input prog_type prog,
                                            input byte_type ch);
      match_type  r;
      logic [3:0] best;
      logic       ok;
      int         pi;
      best = '0;
      for (int k = 1; k <= PatMax; k++) begin
         ok = (k <= int'(prog) + 1) && (k <= PAT_LEN[idx]) && (PAT_TEXT[idx][k-1] == ch);
         for (int j = 0; j < PatMax - 1; j++) begin
            if (j < k - 1) begin
               pi = int'(prog) - k + 1 + j;
               if (pi >= 0 && pi < PatMax) begin
                  ok = ok && (PAT_TEXT[idx][pi] == PAT_TEXT[idx][j]);
               end else begin
                  ok = 1'b0;
               end
            end
         end
         if (ok) begin
            best = 4'(k);
         end
      end
      r.hit  = (best == 4'(PAT_LEN[idx]));
      r.prog = r.hit ? PAT_BORDER[idx] : best[2:0];
      return r;
   endfunction

endpackage

>>> rtl/atrcs_req_if.sv
`timescale 1ns / 1ps

interface atrcs_req_if;
   logic                valid;
   logic                ready;
   atrcs_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/atrcs_rsp_if.sv
`timescale 1ns / 1ps

interface atrcs_rsp_if;
   logic                valid;
   logic                ready;
   atrcs_pkg::cmd_type  command_issue;
   logic                led_write;
   logic                led_level;
   atrcs_pkg::step_type step_now;

   modport source (output valid, output command_issue, output led_write,
                   output led_level, output step_now, input ready);
   modport sink (input valid, input command_issue, input led_write,
                 input led_level, input step_now, output ready);
endinterface

>>> rtl/at_response_command_sequencer.sv
`timescale 1ns / 1ps

// Watches received modem bytes, one item per byte, and answers every byte with
// one item: the command to issue (if any), an optional LED write and the command
// step after the byte. Six reply strings are tracked with overlapping prefix
// matchers; OK, prompt, error/fail and the two data markers act by priority and
// clear the match history. One byte is taken per clock cycle while the result
// side is not stalled; a byte passes an input register and a result register,
// and its item is offered from the result register, unless an earlier item is
// still waiting on the result side. The matcher and priority logic between the
// two registers is the only work, so throughput is one item per cycle when not stalled.

module at_response_command_sequencer (
   input  logic        clock,
   input  logic        reset,
   atrcs_req_if.sink   req_chan,
   atrcs_rsp_if.source rsp_chan
);

   localparam int NP = atrcs_pkg::NumPatterns;

   logic                 in_vld_ff;
   atrcs_pkg::byte_type  in_byte_ff;
   logic                 out_vld_ff;
   atrcs_pkg::cmd_type   out_cmd_ff, out_cmd_in;
   logic                 out_lw_ff, out_lw_in;
   logic                 out_ll_ff, out_ll_in;
   atrcs_pkg::step_type  out_step_ff;

   atrcs_pkg::step_type  step_ff, step_in;
   atrcs_pkg::prog_type  prog_ff [NP];
   atrcs_pkg::match_type match [NP];
   logic [NP-1:0]        seen_ff, seen_in, hits;
   logic                 fire;
   logic                 advance;

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;

   for (genvar i = 0; i < NP; i++) begin : g_match
      assign match[i] = atrcs_pkg::match_next(i, prog_ff[i], in_byte_ff);
      assign hits[i]  = match[i].hit;
   end

   assign seen_in = seen_ff | hits;

   // priority rules
   always_comb begin
      step_in    = step_ff;
      out_cmd_in = atrcs_pkg::CMD_NONE;
      out_lw_in  = 1'b0;
      out_ll_in  = 1'b0;
      fire       = 1'b1;
      if (seen_in[atrcs_pkg::PAT_OK] && step_ff < atrcs_pkg::STEP_ANNOUNCE) begin
         step_in    = step_ff + 3'd1;
         out_cmd_in = step_ff + 3'd1;
      end else if (seen_in[atrcs_pkg::PAT_PROMPT] && step_ff == atrcs_pkg::STEP_ANNOUNCE) begin
         step_in    = atrcs_pkg::CMD_SEND;
         out_cmd_in = atrcs_pkg::CMD_SEND;
      end else if (seen_in[atrcs_pkg::PAT_ERROR] || seen_in[atrcs_pkg::PAT_FAIL]) begin
         step_in    = atrcs_pkg::CMD_JOIN;
         out_cmd_in = atrcs_pkg::CMD_JOIN;
      end else if (seen_in[atrcs_pkg::PAT_LED_ON]) begin
         out_lw_in = 1'b1;
         out_ll_in = 1'b1;
      end else if (seen_in[atrcs_pkg::PAT_LED_OFF]) begin
         out_lw_in = 1'b1;
      end else begin
         fire = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         step_ff    <= '0;
         seen_ff    <= '0;
         for (int i = 0; i < NP; i++) begin
            prog_ff[i] <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
         if (advance) begin
            step_ff <= step_in;
            seen_ff <= fire ? '0 : seen_in;
            for (int i = 0; i < NP; i++) begin
               prog_ff[i] <= fire ? '0 : match[i].prog;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         out_cmd_ff  <= out_cmd_in;
         out_lw_ff   <= out_lw_in;
         out_ll_ff   <= out_ll_in;
         out_step_ff <= step_in;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.command_issue = out_cmd_ff;
   assign rsp_chan.led_write     = out_lw_ff;
   assign rsp_chan.led_level     = out_ll_ff;
   assign rsp_chan.step_now      = out_step_ff;

endmodule

>>> rtl/atrcs_checker.sv
`timescale 1ns / 1ps

module atrcs_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input atrcs_pkg::cmd_type  rsp_command_issue,
   input logic                rsp_led_write,
   input logic                rsp_led_level,
   input atrcs_pkg::step_type rsp_step_now
);

   // a command always moves the step to that command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_issue != atrcs_pkg::CMD_NONE |->
         rsp_step_now == rsp_command_issue)
      else $error("command issued without matching step");

   // only one rule acts per byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led_write |-> rsp_command_issue == atrcs_pkg::CMD_NONE)
      else $error("led write and command on the same item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_led_write |-> !rsp_led_level)
      else $error("led level without led write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_now <= atrcs_pkg::CMD_SEND)
      else $error("step out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_now)
         && $stable(rsp_command_issue))
      else $error("stalled item changed");

endmodule

bind at_response_command_sequencer atrcs_checker u_atrcs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_command_issue (rsp_chan.command_issue),
   .rsp_led_write     (rsp_chan.led_write),
   .rsp_led_level     (rsp_chan.led_level),
   .rsp_step_now      (rsp_chan.step_now)
);
